[sv/rsl_pkg.sv]
`timescale 1ns / 1ps

package rsl_pkg;

  // Field widths
  localparam int COORD_BITS   = 12;
  localparam int LUMA_BITS    = 16;
  localparam int CENTER_BITS  = 14;
  localparam int CFG_IDX_BITS = 2;

  // Offset and distance widths
  localparam int DIFF_BITS = ((COORD_BITS + 1 > CENTER_BITS) ? COORD_BITS + 1 : CENTER_BITS) + 1;
  localparam int ABS_BITS  = DIFF_BITS - 1;
  localparam int SQ_BITS   = 2 * ABS_BITS;
  localparam int D2_BITS   = SQ_BITS + 1;

  // Near region: distance below 160
  localparam int NEAR_LIMIT    = 160;
  localparam int NEAR_LIMIT_SQ = NEAR_LIMIT * NEAR_LIMIT;
  localparam int NEAR_D2_BITS  = $clog2(NEAR_LIMIT_SQ);

  // Square root with 8 fraction bits, two result bits per stage
  localparam int FRAC_BITS    = 8;
  localparam int ROOT_BITS    = (NEAR_D2_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_BITS     = 2 * ROOT_BITS;
  localparam int REM_BITS     = ROOT_BITS + 2;
  localparam int SQRT_STEPS   = 2;
  localparam int SQRT_STAGES  = ROOT_BITS / SQRT_STEPS;

  // Scale factor in Q1.16
  localparam int Q16_BITS    = 16;
  localparam int FACTOR_BITS = Q16_BITS + 1;
  localparam int UNITY_Q16   = 1 << Q16_BITS;
  localparam int FAR_FACTOR  = 13107;

  // Falloff 0.005 per pixel: q = floor(root * 32 / 25), divide by reciprocal
  localparam int FALL_SHIFT = 5;
  localparam int FALL_DIV   = 25;
  localparam int X_BITS     = ROOT_BITS + FALL_SHIFT;
  localparam int DIV_SHIFT  = 26;
  localparam int DIV_RECIP  = (1 << DIV_SHIFT) / FALL_DIV + 1;
  localparam int RECIP_BITS = 22;
  localparam int Q_BITS     = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1
  } cfg_idx_t;

  // Data that rides alongside the distance math
  typedef struct packed {
    logic                 near;
    logic [LUMA_BITS-1:0] luma;
  } side_t;

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
    logic [RAD_BITS-1:0]  rad;
  } sqrt_t;

  // Pipeline advance control shared by all stages
  typedef struct packed {
    logic en;
  } pipe_ctrl_t;

endpackage

[sv/rsl_pix_if.sv]
`timescale 1ns / 1ps

interface rsl_pix_if
  import rsl_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;
  logic [LUMA_BITS-1:0]  luma_in;

  modport source (output valid, output pixel_col, output pixel_row, output luma_in,
                  input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, input luma_in,
                  output ready);
endinterface

[sv/rsl_luma_if.sv]
`timescale 1ns / 1ps

interface rsl_luma_if
  import rsl_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [LUMA_BITS-1:0] luma_out;

  modport source (output valid, output luma_out, input ready);
  modport sink   (input valid, input luma_out, output ready);
endinterface

[sv/rsl_cfg_if.sv]
`timescale 1ns / 1ps

interface rsl_cfg_if
  import rsl_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [CENTER_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/rsl_dist.sv]
`timescale 1ns / 1ps

module rsl_dist
  import rsl_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  pipe_ctrl_t                    ctrl,
  input  logic                          in_valid,
  input  logic [COORD_BITS-1:0]         pixel_col,
  input  logic [COORD_BITS-1:0]         pixel_row,
  input  logic [LUMA_BITS-1:0]          luma,
  input  logic signed [CENTER_BITS-1:0] center_x,
  input  logic signed [CENTER_BITS-1:0] center_y,
  output logic                          out_valid,
  output logic [NEAR_D2_BITS-1:0]       d2,
  output side_t                         side
);

  logic signed [DIFF_BITS-1:0] dx;
  logic signed [DIFF_BITS-1:0] dy;
  logic [ABS_BITS-1:0]         adx;
  logic [ABS_BITS-1:0]         ady;
  logic [D2_BITS-1:0]          d2_sum;

  logic                  v1_r, v2_r, v3_r;
  logic [ABS_BITS-1:0]   adx_r, ady_r;
  logic [LUMA_BITS-1:0]  luma1_r, luma2_r;
  logic [SQ_BITS-1:0]    sqx_r, sqy_r;
  logic [NEAR_D2_BITS-1:0] d2_r;
  side_t                 side_r;

  // Stage 1: offsets from the center and their magnitudes
  always_comb begin
    dx  = DIFF_BITS'(signed'({1'b0, pixel_col})) - DIFF_BITS'(center_x);
    dy  = DIFF_BITS'(signed'({1'b0, pixel_row})) - DIFF_BITS'(center_y);
    adx = dx[DIFF_BITS-1] ? ABS_BITS'(-dx) : dx[ABS_BITS-1:0];
    ady = dy[DIFF_BITS-1] ? ABS_BITS'(-dy) : dy[ABS_BITS-1:0];
  end

  assign d2_sum = D2_BITS'(sqx_r) + D2_BITS'(sqy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ctrl.en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      adx_r       <= adx;
      ady_r       <= ady;
      luma1_r     <= luma;
      // Stage 2: squares
      sqx_r       <= adx_r * adx_r;
      sqy_r       <= ady_r * ady_r;
      luma2_r     <= luma1_r;
      // Stage 3: squared distance and near test
      d2_r        <= d2_sum[NEAR_D2_BITS-1:0];
      side_r.near <= (d2_sum < D2_BITS'(NEAR_LIMIT_SQ));
      side_r.luma <= luma2_r;
    end
  end

  assign out_valid = v3_r;
  assign d2        = d2_r;
  assign side      = side_r;

endmodule

[sv/rsl_isqrt.sv]
`timescale 1ns / 1ps

module rsl_isqrt
  import rsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  pipe_ctrl_t              ctrl,
  input  logic                    in_valid,
  input  logic [NEAR_D2_BITS-1:0] d2,
  input  side_t                   side_in,
  output logic                    out_valid,
  output logic [ROOT_BITS-1:0]    root,
  output side_t                   side_out
);

  // One restoring digit step: bring down two radicand bits, try root*4+1
  function automatic sqrt_t sqrt_step(sqrt_t cur);
    sqrt_t               nxt;
    logic [REM_BITS-1:0] rem_pre;
    logic [REM_BITS-1:0] trial;
    rem_pre = {cur.rem[REM_BITS-3:0], cur.rad[RAD_BITS-1 -: 2]};
    trial   = {cur.root, 2'b01};
    nxt.rad = {cur.rad[RAD_BITS-3:0], 2'b00};
    if (rem_pre >= trial) begin
      nxt.rem  = rem_pre - trial;
      nxt.root = {cur.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_pre;
      nxt.root = {cur.root[ROOT_BITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

  sqrt_t init;
  sqrt_t sq_r    [SQRT_STAGES];
  side_t side_r  [SQRT_STAGES];
  logic  valid_r [SQRT_STAGES];

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.rad  = RAD_BITS'({d2, {(2 * FRAC_BITS){1'b0}}});
  end

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sqrt_t cur;
    sqrt_t nxt;
    side_t side_prev;
    logic  valid_prev;

    if (s == 0) begin : g_first
      assign cur        = init;
      assign side_prev  = side_in;
      assign valid_prev = in_valid;
    end else begin : g_rest
      assign cur        = sq_r[s-1];
      assign side_prev  = side_r[s-1];
      assign valid_prev = valid_r[s-1];
    end

    always_comb begin
      nxt = cur;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        nxt = sqrt_step(nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (ctrl.en) begin
        valid_r[s] <= valid_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.en) begin
        sq_r[s]   <= nxt;
        side_r[s] <= side_prev;
      end
    end
  end

  assign out_valid = valid_r[SQRT_STAGES-1];
  assign root      = sq_r[SQRT_STAGES-1].root;
  assign side_out  = side_r[SQRT_STAGES-1];

endmodule

[sv/rsl_scale.sv]
`timescale 1ns / 1ps

module rsl_scale
  import rsl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  pipe_ctrl_t           ctrl,
  input  logic                 in_valid,
  input  logic [ROOT_BITS-1:0] root,
  input  side_t                side_in,
  output logic                 out_valid,
  output logic [LUMA_BITS-1:0] luma_out
);

  localparam int PA_BITS = X_BITS + RECIP_BITS;
  localparam int PB_BITS = LUMA_BITS + FACTOR_BITS;

  logic [PA_BITS-1:0]     prod_a;
  logic [FACTOR_BITS-1:0] factor;
  logic [PB_BITS-1:0]     prod_b;

  logic                 va_r, vb_r;
  logic [Q_BITS-1:0]    q_r;
  side_t                side_a_r;
  logic [LUMA_BITS-1:0] luma_r;

  // Stage A: q = floor(root * 32 / 25) by reciprocal multiply
  assign prod_a = PA_BITS'({root, {FALL_SHIFT{1'b0}}}) * PA_BITS'(DIV_RECIP);

  // Stage B: pick the factor and scale the luminance
  always_comb begin
    if (side_a_r.near) begin
      factor = FACTOR_BITS'(UNITY_Q16) - FACTOR_BITS'(q_r);
    end else begin
      factor = FACTOR_BITS'(FAR_FACTOR);
    end
    prod_b = PB_BITS'(side_a_r.luma) * PB_BITS'(factor);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (ctrl.en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      q_r      <= prod_a[DIV_SHIFT +: Q_BITS];
      side_a_r <= side_in;
      luma_r   <= prod_b[Q16_BITS +: LUMA_BITS];
    end
  end

  assign out_valid = vb_r;
  assign luma_out  = luma_r;

endmodule

[sv/radial_spotlight_luminance.sv]
`timescale 1ns / 1ps

// Radial spotlight: each pixel beat carries its column, row and Q0.16 luminance,
// and one beat comes out per pixel, in order. Pixels at distance 160 or more from
// the programmed center (center_x, center_y, signed, may lie off the image) are
// scaled by 0.2; nearer pixels are scaled by 1 - 0.005 * distance, with the
// distance taken from an exact integer square root with 8 fraction bits and all
// products truncated. The block takes one pixel every clock while the output
// is not stalled. It has three stages for offsets, squares and squared distance,
// eight stages of the square root at two result bits per stage, and two stages
// for the falloff multiply and the luminance multiply, the last of which is the
// output register. All stages advance together whenever the output register is
// empty or being taken, so back-pressure on the output holds the whole pipeline
// without losing or repeating a beat. Program the center only while no pixels
// are in flight; configuration writes are always ready and an unknown register
// index is dropped.
module radial_spotlight_luminance
  import rsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rsl_cfg_if.sink     cfg_wr,
  rsl_pix_if.sink     in_pix,
  rsl_luma_if.source  out_luma
);

  logic signed [CENTER_BITS-1:0] center_x_r, center_x_nxt;
  logic signed [CENTER_BITS-1:0] center_y_r, center_y_nxt;
  cfg_idx_t                      cfg_idx;

  pipe_ctrl_t ctrl;

  logic                    dist_valid;
  logic [NEAR_D2_BITS-1:0] dist_d2;
  side_t                   dist_side;

  logic                    sqrt_valid;
  logic [ROOT_BITS-1:0]    sqrt_root;
  side_t                   sqrt_side;

  logic                    scale_valid;
  logic [LUMA_BITS-1:0]    scale_luma;

  // Configuration: always ready, decode the register index
  assign cfg_wr.ready = 1'b1;
  assign cfg_idx      = cfg_idx_t'(cfg_wr.index);

  always_comb begin
    center_x_nxt = center_x_r;
    center_y_nxt = center_y_r;
    if (cfg_wr.valid) begin
      unique case (cfg_idx)
        CFG_CENTER_X: center_x_nxt = cfg_wr.data;
        CFG_CENTER_Y: center_y_nxt = cfg_wr.data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else begin
      center_x_r <= center_x_nxt;
      center_y_r <= center_y_nxt;
    end
  end

  // Advance every stage when the output register is free or being drained;
  // otherwise hold everything in place.
  assign ctrl.en      = !scale_valid || out_luma.ready;
  assign in_pix.ready = ctrl.en;

  rsl_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (in_pix.valid),
    .pixel_col (in_pix.pixel_col),
    .pixel_row (in_pix.pixel_row),
    .luma      (in_pix.luma_in),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .out_valid (dist_valid),
    .d2        (dist_d2),
    .side      (dist_side)
  );

  rsl_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (dist_valid),
    .d2        (dist_d2),
    .side_in   (dist_side),
    .out_valid (sqrt_valid),
    .root      (sqrt_root),
    .side_out  (sqrt_side)
  );

  rsl_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_valid  (sqrt_valid),
    .root      (sqrt_root),
    .side_in   (sqrt_side),
    .out_valid (scale_valid),
    .luma_out  (scale_luma)
  );

  assign out_luma.valid    = scale_valid;
  assign out_luma.luma_out = scale_luma;

endmodule

[tb/sv/luma_falloff_checker.sv]
`timescale 1ns / 1ps

module luma_falloff_checker
  import rsl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rsl_cfg_if   cfg,
  rsl_pix_if   pix,
  rsl_luma_if  luma,
  output int   mismatches,
  output int   luma_due_count,
  output int   near_seen,
  output int   far_seen
);

  localparam longint NEAR_SQ      = 160 * 160;
  localparam longint FAR_SCALE    = 13107;   // floor(0.2 * 2^16)
  localparam longint UNITY        = 65536;
  localparam int     REPORT_LIMIT = 10;

  typedef struct {
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
    logic [LUMA_BITS-1:0]  luma_in;
    logic [LUMA_BITS-1:0]  luma_out;
  } luma_due_t;

  luma_due_t luma_due[$];
  logic signed [CENTER_BITS-1:0] center_col;
  logic signed [CENTER_BITS-1:0] center_row;

  // Largest r with r*r <= v; the radicand stays below 2^31 here.
  function automatic longint root_floor(input longint v);
    longint r;
    longint trial;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = r | (longint'(1) << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [LUMA_BITS-1:0] attenuated_luma(
    input  logic [COORD_BITS-1:0] col,
    input  logic [COORD_BITS-1:0] row,
    input  logic [LUMA_BITS-1:0]  luma_in,
    output logic                  is_near
  );
    longint dx;
    longint dy;
    longint d2;
    longint factor;
    dx = longint'(col) - longint'(center_col);
    dy = longint'(row) - longint'(center_row);
    d2 = dx * dx + dy * dy;
    is_near = (d2 < NEAR_SQ);
    // distance in Q.8, then 1 - dist/200 as Q1.16: 65536/51200 = 32/25
    if (is_near) factor = UNITY - (root_floor(d2 << 16) * 32) / 25;
    else factor = FAR_SCALE;
    return LUMA_BITS'((longint'(luma_in) * factor) >> 16);
  endfunction

  always @(posedge clk) begin : track
    luma_due_t entry;
    logic      is_near;
    if (!rst_n) begin
      luma_due.delete();
      center_col = '0;
      center_row = '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CENTER_X: center_col = cfg.data;
          CFG_CENTER_Y: center_row = cfg.data;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        entry.col      = pix.pixel_col;
        entry.row      = pix.pixel_row;
        entry.luma_in  = pix.luma_in;
        entry.luma_out = attenuated_luma(pix.pixel_col, pix.pixel_row, pix.luma_in, is_near);
        if (is_near) near_seen++;
        else far_seen++;
        luma_due.push_back(entry);
      end
      if (luma.valid && luma.ready) begin
        if (luma_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("[%0t] luma_out beat %h with no pixel pending", $realtime, luma.luma_out);
          mismatches++;
        end else begin
          entry = luma_due.pop_front();
          if (luma.luma_out !== entry.luma_out) begin
            if (mismatches < REPORT_LIMIT)
              $display("[%0t] pixel (%0d,%0d) luma_in %h: luma_out expected %h, got %h",
                       $realtime, entry.col, entry.row, entry.luma_in, entry.luma_out,
                       luma.luma_out);
            mismatches++;
          end
        end
      end
    end
    luma_due_count = luma_due.size();
  end

endmodule

[tb/sv/tb_radial_spotlight_luminance.sv]
`timescale 1ns / 1ps

module tb_radial_spotlight_luminance;
  import rsl_pkg::*;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 7;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 20;    // pipeline is 13 deep
  localparam int PHASES           = 8;
  localparam int PIXELS_PER_PHASE = 200;
  localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
  localparam int LUMA_MAX         = (1 << LUMA_BITS) - 1;
  localparam int CENTER_SPAN      = (1 << CENTER_BITS) - 1;
  localparam int NEAR_SPAN        = 170;   // just past the 160 pixel radius

  // Indexes the block has no register for; writes there must be dropped.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_TOGGLE, SINK_BLOCKED} sink_mode_e;

  logic clk;
  logic rst_n;

  rsl_cfg_if  cfg_wr ();
  rsl_pix_if  in_pix ();
  rsl_luma_if out_luma ();

  int mismatches;
  int luma_due_count;
  int near_seen;
  int far_seen;
  int burst_left;
  int settings_done;
  int idle_cycles;

  radial_spotlight_luminance DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_pix   (in_pix),
    .out_luma (out_luma)
  );

  // The checker sees every beat on all three channels and keeps the verdict count.
  luma_falloff_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_wr),
    .pix            (in_pix),
    .luma           (out_luma),
    .mismatches     (mismatches),
    .luma_due_count (luma_due_count),
    .near_seen      (near_seen),
    .far_seen       (far_seen)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Drive one pixel beat. The sender works in bursts: when a burst runs out,
  // drop valid for a random gap (sometimes none) and start a new burst.
  // Valid stays high on return so back-to-back beats never toggle it.
  task automatic send_pixel(input int col, input int row, input int luma);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_pix.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 64);
    end
    in_pix.valid     <= 1'b1;
    in_pix.pixel_col <= col[COORD_BITS-1:0];
    in_pix.pixel_row <= row[COORD_BITS-1:0];
    in_pix.luma_in   <= luma[LUMA_BITS-1:0];
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // One register beat; valid is left high for the caller to drop.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value[CENTER_BITS-1:0];
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Move the spotlight. Hold off until every pixel in flight has come out,
  // since the center may only change while the pipeline is empty. Optionally
  // follow up with writes to the unused indexes, which must change nothing.
  task automatic set_center(input int cx, input int cy, input bit with_spare);
    while (luma_due_count != 0) @(posedge clk);
    @(negedge clk);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    if (with_spare) begin
      write_reg(CFG_SPARE_2, $urandom_range(0, CENTER_SPAN));
      write_reg(CFG_SPARE_3, $urandom_range(0, CENTER_SPAN));
    end
    cfg_wr.valid <= 1'b0;
    settings_done++;
  endtask

  function automatic int clamp_coord(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // Result sink: every window of cycles picks a stall pattern of its own,
  // from wide open through random stalls to long blocked stretches.
  initial begin : result_sink
    sink_mode_e mode;
    int         window;
    mode           = SINK_OPEN;
    window         = 0;
    out_luma.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        mode   = sink_mode_e'($urandom_range(0, 4));
        window = $urandom_range(30, 150);
      end
      window--;
      case (mode)
        SINK_OPEN:   out_luma.ready <= 1'b1;
        SINK_LIGHT:  out_luma.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY:  out_luma.ready <= ($urandom_range(0, 3) == 0);
        SINK_TOGGLE: out_luma.ready <= ~out_luma.ready;
        default:     out_luma.ready <= ((window % 32) < 6);
      endcase
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_luma.valid && out_luma.ready) ||
        (cfg_wr.valid && cfg_wr.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[%0t] no beat for %0d cycles", $realtime, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int cx;
    int cy;
    int col;
    int row;
    int luma;
    int pick;

    burst_left       = 0;
    settings_done    = 0;
    idle_cycles      = 0;
    rst_n            = 1'b0;
    in_pix.valid     = 1'b0;
    in_pix.pixel_col = '0;
    in_pix.pixel_row = '0;
    in_pix.luma_in   = '0;
    cfg_wr.valid     = 1'b0;
    cfg_wr.index     = CFG_CENTER_X;
    cfg_wr.data      = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: center well inside the image.
    cx = 1000;
    cy = 2000;
    set_center(cx, cy, 1'b0);
    send_pixel(cx, cy, LUMA_MAX);             // at the center: passes unchanged
    send_pixel(cx, cy, 0);
    send_pixel(cx + 160, cy, LUMA_MAX);       // exactly 160 away counts as far
    send_pixel(cx + 159, cy, LUMA_MAX);       // last whole pixel still near
    send_pixel(cx, cy - 160, LUMA_MAX);
    send_pixel(cx + 96, cy + 128, LUMA_MAX);  // squared distance right on the edge
    send_pixel(cx + 96, cy + 127, LUMA_MAX);  // one step inside it
    send_pixel(cx - 1, cy - 1, 16'hffff);
    send_pixel(0, 0, 16'haaaa);
    send_pixel(COORD_MAX, COORD_MAX, 16'h5555);
    send_pixel(COORD_MAX, 0, 1);
    send_pixel(0, COORD_MAX, 16'h8000);
    in_pix.valid <= 1'b0;

    // Directed: center at the image origin.
    set_center(0, 0, 1'b0);
    send_pixel(0, 0, LUMA_MAX);
    send_pixel(159, 0, LUMA_MAX);
    send_pixel(160, 0, LUMA_MAX);
    send_pixel(113, 113, LUMA_MAX);
    in_pix.valid <= 1'b0;

    // Directed: register extremes, the widest distances the block can see.
    set_center(-(1 << (CENTER_BITS - 1)), -(1 << (CENTER_BITS - 1)), 1'b0);
    send_pixel(COORD_MAX, COORD_MAX, LUMA_MAX);
    send_pixel(0, 0, LUMA_MAX);
    in_pix.valid <= 1'b0;
    set_center((1 << (CENTER_BITS - 1)) - 1, (1 << (CENTER_BITS - 1)) - 1, 1'b0);
    send_pixel(0, 0, LUMA_MAX);
    send_pixel(COORD_MAX, COORD_MAX, LUMA_MAX);
    in_pix.valid <= 1'b0;

    // Directed: writes to unused indexes must leave the center alone.
    set_center(50, 60, 1'b1);
    send_pixel(50, 60, LUMA_MAX);
    in_pix.valid <= 1'b0;

    // Random phases: move the center, then stream pixels, most clustered around it
    // so that they can land in the near region, with the rest spread over the image.
    for (int p = 0; p < PHASES; p++) begin
      pick = $urandom_range(0, 5);
      if (pick <= 2) begin
        cx = $urandom_range(0, COORD_MAX);
        cy = $urandom_range(0, COORD_MAX);
      end else if (pick == 3) begin
        // just off the image edge, near pixels still reachable
        cx = ($urandom_range(0, 1) == 0) ? -int'($urandom_range(1, 150))
                                         : COORD_MAX + int'($urandom_range(1, 150));
        cy = $urandom_range(0, COORD_MAX);
      end else begin
        // anywhere in the 14-bit signed range
        cx = $urandom_range(0, CENTER_SPAN) - (1 << (CENTER_BITS - 1));
        cy = $urandom_range(0, CENTER_SPAN) - (1 << (CENTER_BITS - 1));
      end
      set_center(cx, cy, $urandom_range(0, 1));
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          col = clamp_coord(cx + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
          row = clamp_coord(cy + int'($urandom_range(0, 2 * NEAR_SPAN)) - NEAR_SPAN);
        end else begin
          col = $urandom_range(0, COORD_MAX);
          row = $urandom_range(0, COORD_MAX);
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) luma = 0;
        else if (pick == 1) luma = LUMA_MAX;
        else luma = $urandom_range(0, LUMA_MAX);
        send_pixel(col, row, luma);
      end
      in_pix.valid <= 1'b0;
    end

    // Drain: wait for every pixel to come out, then watch for stray beats.
    while (luma_due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d pixel beats over %0d center settings, with gaps and output stalls",
             near_seen + far_seen, settings_done);
    $display("%0d pixels fell inside the 160 pixel spotlight, %0d beyond it",
             near_seen, far_seen);
    if (mismatches == 0 && luma_due_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
sv/rsl_pkg.sv
sv/rsl_pix_if.sv
sv/rsl_luma_if.sv
sv/rsl_cfg_if.sv
sv/rsl_dist.sv
sv/rsl_isqrt.sv
sv/rsl_scale.sv
sv/radial_spotlight_luminance.sv
tb/sv/luma_falloff_checker.sv
tb/sv/tb_radial_spotlight_luminance.sv
